// File: rtl/cau_pkg.sv
// Shared types and defaults for the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned CAU_DATA_WIDTH = 32;
  localparam int unsigned CAU_FRAC_BITS  = 16;

  // Operation codes carried on the input tuser.
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_EQ   = 3'd5
  } cau_op_e;

  // Per-word status that travels with the word down the pipeline.
  typedef struct packed {
    logic is_div;
    logic div_zero;
    logic is_equal;
    logic ovf;
  } cau_flags_t;

  // Quotient side information: result signs and early overflow detection.
  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic ovc_re;
    logic ovc_im;
  } cau_qstat_t;

endpackage

// File: rtl/cau_mult.sv
// Front pipeline: decode, partial products, products, combine and magnitude.
module cau_mult #(
  parameter int unsigned DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0]                kind_i,
  input  logic [DATA_WIDTH-1:0]     a_re_i,
  input  logic [DATA_WIDTH-1:0]     a_im_i,
  input  logic [DATA_WIDTH-1:0]     b_re_i,
  input  logic [DATA_WIDTH-1:0]     b_im_i,
  output logic                      valid_o,
  output logic [2:0]                kind_o,
  output logic [DATA_WIDTH-1:0]     smp_re_o,
  output logic [DATA_WIDTH-1:0]     smp_im_o,
  output logic                      smp_ovf_o,
  output logic                      eq_o,
  output logic                      neg_re_o,
  output logic                      neg_im_o,
  output logic [2*DATA_WIDTH:0]     mag_re_o,
  output logic [2*DATA_WIDTH:0]     mag_im_o,
  output logic [2*DATA_WIDTH-1:0]   den_o
);
  import cau_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned LW = (DW + 1) / 2;
  localparam int unsigned HW = DW - LW;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned MW = 2 * DW + 1;
  localparam int unsigned NP = 6;
  localparam int unsigned NS = 5;
  // Operand pairs: ar*br, ai*bi, ar*bi, ai*br, br*br, bi*bi.
  localparam int unsigned PX [NP] = '{0, 1, 0, 1, 2, 3};
  localparam int unsigned PY [NP] = '{2, 3, 3, 2, 2, 3};

  function automatic logic [DW:0] sat_ext(input logic [DW:0] s);
    logic ovf;
    logic [DW-1:0] val;
    ovf = s[DW] != s[DW-1];
    if (ovf) begin
      val = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      val = s[DW-1:0];
    end
    return {ovf, val};
  endfunction

  logic [DW-1:0] opv [4];
  logic [3:0]    sgn;
  logic [DW-1:0] mag [4];
  logic [DW:0]   xr, xi, yr, yi, sre, sim, sat_re, sat_im;

  assign opv = '{a_re_i, a_im_i, b_re_i, b_im_i};
  assign xr  = {a_re_i[DW-1], a_re_i};
  assign xi  = {a_im_i[DW-1], a_im_i};
  assign yr  = {b_re_i[DW-1], b_re_i};
  assign yi  = {b_im_i[DW-1], b_im_i};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sgn[i] = opv[i][DW-1];
      mag[i] = sgn[i] ? DW'(~opv[i] + DW'(1)) : opv[i];
    end
  end

  // Add, subtract and conjugate finish here and ride along.
  always_comb begin
    sre = '0;
    sim = '0;
    case (kind_i)
      OP_ADD: begin
        sre = xr + yr;
        sim = xi + yi;
      end
      OP_SUB: begin
        sre = xr - yr;
        sim = xi - yi;
      end
      OP_CONJ: begin
        sre = xr;
        sim = (DW+1)'(0) - xi;
      end
      default: begin
        sre = '0;
        sim = '0;
      end
    endcase
  end

  assign sat_re = sat_ext(sre);
  assign sat_im = sat_ext(sim);

  logic [NS-1:0] v_q;
  logic [2:0]    kind_q [NS];
  logic [DW-1:0] sre_q  [NS];
  logic [DW-1:0] sim_q  [NS];
  logic          sov_q  [NS];
  logic          seq_q  [NS];

  logic [3:0]         sgn1_q;
  logic [DW-1:0]      mag1_q [4];
  logic [2*LW-1:0]    ll2_q  [NP];
  logic [LW+HW-1:0]   lh2_q  [NP];
  logic [LW+HW-1:0]   hl2_q  [NP];
  logic [2*HW-1:0]    hh2_q  [NP];
  logic [NP-1:0]      psg2_q;
  logic [PW-1:0]      pm     [NP];
  logic [MW-1:0]      prd3_q [4];
  logic [PW-1:0]      sq3_q  [2];
  logic [MW-1:0]      nre4_q, nim4_q;
  logic [PW-1:0]      den4_q, den5_q;
  logic               neg5_re_q, neg5_im_q;
  logic [MW-1:0]      mag5_re_q, mag5_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      pm[k] = PW'(ll2_q[k]) + (PW'(lh2_q[k]) << LW) + (PW'(hl2_q[k]) << LW)
            + (PW'(hh2_q[k]) << (2 * LW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Sideband shift line.
      kind_q[0] <= kind_i;
      sre_q[0]  <= sat_re[DW-1:0];
      sim_q[0]  <= sat_im[DW-1:0];
      sov_q[0]  <= sat_re[DW] | sat_im[DW];
      seq_q[0]  <= (kind_i == OP_EQ) && (a_re_i == b_re_i) && (a_im_i == b_im_i);
      for (int s = 1; s < NS; s++) begin
        kind_q[s] <= kind_q[s-1];
        sre_q[s]  <= sre_q[s-1];
        sim_q[s]  <= sim_q[s-1];
        sov_q[s]  <= sov_q[s-1];
        seq_q[s]  <= seq_q[s-1];
      end
      // Stage 1: signs and magnitudes.
      sgn1_q <= sgn;
      for (int i = 0; i < 4; i++) begin
        mag1_q[i] <= mag[i];
      end
      // Stage 2: half-width partial products.
      for (int k = 0; k < NP; k++) begin
        ll2_q[k]  <= mag1_q[PX[k]][LW-1:0] * mag1_q[PY[k]][LW-1:0];
        lh2_q[k]  <= mag1_q[PX[k]][LW-1:0] * mag1_q[PY[k]][DW-1:LW];
        hl2_q[k]  <= mag1_q[PX[k]][DW-1:LW] * mag1_q[PY[k]][LW-1:0];
        hh2_q[k]  <= mag1_q[PX[k]][DW-1:LW] * mag1_q[PY[k]][DW-1:LW];
        psg2_q[k] <= sgn1_q[PX[k]] ^ sgn1_q[PY[k]];
      end
      // Stage 3: signed cross products and the two squares.
      for (int k = 0; k < 4; k++) begin
        prd3_q[k] <= psg2_q[k] ? MW'(0) - MW'(pm[k]) : MW'(pm[k]);
      end
      sq3_q[0] <= pm[4];
      sq3_q[1] <= pm[5];
      // Stage 4: multiply or divide numerators, and the denominator.
      if (kind_q[2] == OP_MUL) begin
        nre4_q <= prd3_q[0] - prd3_q[1];
        nim4_q <= prd3_q[2] + prd3_q[3];
      end else begin
        nre4_q <= prd3_q[0] + prd3_q[1];
        nim4_q <= prd3_q[3] - prd3_q[2];
      end
      den4_q <= sq3_q[0] + sq3_q[1];
      // Stage 5: sign and magnitude.
      neg5_re_q <= nre4_q[MW-1];
      neg5_im_q <= nim4_q[MW-1];
      mag5_re_q <= nre4_q[MW-1] ? MW'(0) - nre4_q : nre4_q;
      mag5_im_q <= nim4_q[MW-1] ? MW'(0) - nim4_q : nim4_q;
      den5_q    <= den4_q;
    end
  end

  assign valid_o   = v_q[NS-1];
  assign kind_o    = kind_q[NS-1];
  assign smp_re_o  = sre_q[NS-1];
  assign smp_im_o  = sim_q[NS-1];
  assign smp_ovf_o = sov_q[NS-1];
  assign eq_o      = seq_q[NS-1];
  assign neg_re_o  = neg5_re_q;
  assign neg_im_o  = neg5_im_q;
  assign mag_re_o  = mag5_re_q;
  assign mag_im_o  = mag5_im_q;
  assign den_o     = den5_q;

endmodule

// File: rtl/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module cau_div #(
  parameter int unsigned DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  cau_pkg::cau_flags_t        flags_i,
  input  logic [DATA_WIDTH-1:0]      pre_re_i,
  input  logic [DATA_WIDTH-1:0]      pre_im_i,
  input  logic                       neg_re_i,
  input  logic                       neg_im_i,
  input  logic [2*DATA_WIDTH:0]      mag_re_i,
  input  logic [2*DATA_WIDTH:0]      mag_im_i,
  input  logic [2*DATA_WIDTH-1:0]    den_i,
  output logic                       valid_o,
  output cau_pkg::cau_flags_t        flags_o,
  output logic [DATA_WIDTH-1:0]      pre_re_o,
  output logic [DATA_WIDTH-1:0]      pre_im_o,
  output cau_pkg::cau_qstat_t        qst_o,
  output logic [DATA_WIDTH-1:0]      q_re_o,
  output logic [DATA_WIDTH-1:0]      q_im_o,
  output logic [2*DATA_WIDTH:0]      r_re_o,
  output logic [2*DATA_WIDTH:0]      r_im_o,
  output logic [2*DATA_WIDTH-1:0]    den_o
);
  import cau_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned MW = 2 * DW + 1;
  localparam int unsigned RW = 2 * DW + 1;
  localparam int unsigned NW = MW + FRAC_BITS;
  localparam int unsigned TW = NW - DW;
  localparam int unsigned CW = (TW > PW) ? TW : PW;

  logic [MW-1:0] mag_in [2];
  logic [NW-1:0] nf     [2];
  logic [1:0]    ovc;

  assign mag_in = '{mag_re_i, mag_im_i};

  // The scaled numerator's top bits must stay below the denominator,
  // otherwise the quotient does not fit and the result saturates.
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      nf[c]  = NW'(mag_in[c]) << FRAC_BITS;
      ovc[c] = CW'(nf[c][NW-1:DW]) >= CW'(den_i);
    end
  end

  logic [DW:0]     v_q;
  cau_flags_t      fl_q  [DW+1];
  cau_qstat_t      qs_q  [DW+1];
  logic [DW-1:0]   pre_re_q [DW+1];
  logic [DW-1:0]   pre_im_q [DW+1];
  logic [PW-1:0]   den_q [DW+1];
  logic [RW-1:0]   r_q   [DW+1][2];
  logic [DW-1:0]   q_q   [DW+1][2];
  logic [DW-1:0]   n_q   [DW+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0]     <= flags_i;
      qs_q[0]     <= '{neg_re: neg_re_i, neg_im: neg_im_i, ovc_re: ovc[0], ovc_im: ovc[1]};
      pre_re_q[0] <= pre_re_i;
      pre_im_q[0] <= pre_im_i;
      den_q[0]    <= den_i;
      for (int c = 0; c < 2; c++) begin
        r_q[0][c] <= RW'(nf[c][NW-1:DW]);
        q_q[0][c] <= '0;
        n_q[0][c] <= nf[c][DW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    for (genvar c = 0; c < 2; c++) begin : g_lane
      logic [RW-1:0] t;
      logic          ge;
      assign t  = {r_q[k-1][c][RW-2:0], n_q[k-1][c][DW-1]};
      assign ge = t >= RW'(den_q[k-1]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k][c] <= ge ? t - RW'(den_q[k-1]) : t;
          q_q[k][c] <= {q_q[k-1][c][DW-2:0], ge};
          n_q[k][c] <= n_q[k-1][c] << 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[k]     <= fl_q[k-1];
        qs_q[k]     <= qs_q[k-1];
        pre_re_q[k] <= pre_re_q[k-1];
        pre_im_q[k] <= pre_im_q[k-1];
        den_q[k]    <= den_q[k-1];
      end
    end
  end

  assign valid_o  = v_q[DW];
  assign flags_o  = fl_q[DW];
  assign qst_o    = qs_q[DW];
  assign pre_re_o = pre_re_q[DW];
  assign pre_im_o = pre_im_q[DW];
  assign q_re_o   = q_q[DW][0];
  assign q_im_o   = q_q[DW][1];
  assign r_re_o   = r_q[DW][0];
  assign r_im_o   = r_q[DW][1];
  assign den_o    = den_q[DW];

endmodule

// File: rtl/cau_out.sv
// Quotient rounding, saturation, result select and output register.
module cau_out #(
  parameter int unsigned DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  cau_pkg::cau_flags_t      flags_i,
  input  logic [DATA_WIDTH-1:0]    pre_re_i,
  input  logic [DATA_WIDTH-1:0]    pre_im_i,
  input  cau_pkg::cau_qstat_t      qst_i,
  input  logic [DATA_WIDTH-1:0]    q_re_i,
  input  logic [DATA_WIDTH-1:0]    q_im_i,
  input  logic [2*DATA_WIDTH:0]    r_re_i,
  input  logic [2*DATA_WIDTH:0]    r_im_i,
  input  logic [2*DATA_WIDTH-1:0]  den_i,
  output logic                     valid_o,
  output logic [DATA_WIDTH-1:0]    res_re_o,
  output logic [DATA_WIDTH-1:0]    res_im_o,
  output logic                     is_equal_o,
  output logic                     div_zero_o,
  output logic                     overflow_o
);
  import cau_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned RW = 2 * DW + 1;
  localparam logic [DW:0] LIM_NEG = (DW+1)'(1) << (DW - 1);
  localparam logic [DW:0] LIM_POS = LIM_NEG - (DW+1)'(1);

  logic [DW-1:0] q_in [2];
  logic [RW-1:0] r_in [2];
  logic [1:0]    neg, ovc, sat;
  logic [DW:0]   qq [2];
  logic [DW:0]   lim [2];
  logic [DW-1:0] m [2];
  logic [DW-1:0] dq [2];
  logic [DW-1:0] res_re_d, res_im_d;
  logic          ovf_d;

  assign q_in = '{q_re_i, q_im_i};
  assign r_in = '{r_re_i, r_im_i};
  assign neg  = {qst_i.neg_im, qst_i.neg_re};
  assign ovc  = {qst_i.ovc_im, qst_i.ovc_re};

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      // Round half away from zero on the magnitude.
      qq[c]  = (DW+1)'(q_in[c])
             + (DW+1)'({r_in[c], 1'b0} >= (RW+1)'(den_i));
      lim[c] = neg[c] ? LIM_NEG : LIM_POS;
      sat[c] = ovc[c] | (qq[c] > lim[c]);
      m[c]   = sat[c] ? lim[c][DW-1:0] : qq[c][DW-1:0];
      dq[c]  = neg[c] ? DW'(0) - m[c] : m[c];
    end
  end

  always_comb begin
    if (!flags_i.is_div) begin
      res_re_d = pre_re_i;
      res_im_d = pre_im_i;
      ovf_d    = flags_i.ovf;
    end else if (flags_i.div_zero) begin
      res_re_d = '0;
      res_im_d = '0;
      ovf_d    = 1'b0;
    end else begin
      res_re_d = dq[0];
      res_im_d = dq[1];
      ovf_d    = |sat;
    end
  end

  logic          valid_q;
  logic [DW-1:0] res_re_q, res_im_q;
  logic          eq_q, dz_q, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      eq_q     <= flags_i.is_equal;
      dz_q     <= flags_i.div_zero;
      ovf_q    <= ovf_d;
    end
  end

  assign valid_o    = valid_q;
  assign res_re_o   = res_re_q;
  assign res_im_o   = res_im_q;
  assign is_equal_o = eq_q;
  assign div_zero_o = dz_q;
  assign overflow_o = ovf_q;

endmodule

// File: rtl/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: stream ports and pipeline glue.
//
//   Channel   Dir  Handshake                  Content
//   s_axis    in   s_axis_tvalid_i/tready_o   tdata: a_re, a_im, b_re, b_im; tuser: kind
//   m_axis    out  m_axis_tvalid_o/tready_i   tdata: res_re, res_im; tuser: flags
//
// One word enters per clock cycle while the output is not stalled. Each word passes
// through five front stages, one divider entry stage, one stage per quotient bit,
// and the output register. The quotient loop of the divider sets the depth. The
// whole pipeline advances together whenever the output register is empty or
// being read, so a stall freezes every stage in place and no word is dropped or
// repeated. Reset clears only the valid bits.

module complex_arithmetic_unit_top #(
  parameter int unsigned DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // a_re, a_im, b_re, b_im from bit 0 up, zero padded to whole bytes.
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  // kind.
  input  logic [2:0]                             s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // res_re, res_im from bit 0 up, zero padded to whole bytes.
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata_o,
  // is_equal, div_zero, overflow from bit 0 up.
  output logic [2:0]                             m_axis_tuser_o
);
  import cau_pkg::*;

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned MW  = 2 * DW + 1;
  localparam int unsigned ODW = ((2 * DW + 7) / 8) * 8;
  // Half an output LSB in the full product scale; zero when there are no fraction bits.
  localparam logic [MW:0] HALF    = ((MW+1)'(1) << FRAC_BITS) >> 1;
  localparam logic [MW:0] LIM_NEG = (MW+1)'(1) << (DW - 1);
  localparam logic [MW:0] LIM_POS = LIM_NEG - (MW+1)'(1);

  logic en;
  logic out_valid;

  // Global advance: every stage moves when the output word can move.
  assign en              = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic               f_valid;
  logic [2:0]         f_kind;
  logic [DW-1:0]      f_smp_re, f_smp_im;
  logic               f_smp_ovf, f_eq;
  logic               f_neg_re, f_neg_im;
  logic [MW-1:0]      f_mag_re, f_mag_im;
  logic [PW-1:0]      f_den;

  cau_mult #(
    .DATA_WIDTH(DW)
  ) u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid_i),
    .kind_i    (s_axis_tuser_i),
    .a_re_i    (s_axis_tdata_i[DW-1:0]),
    .a_im_i    (s_axis_tdata_i[2*DW-1:DW]),
    .b_re_i    (s_axis_tdata_i[3*DW-1:2*DW]),
    .b_im_i    (s_axis_tdata_i[4*DW-1:3*DW]),
    .valid_o   (f_valid),
    .kind_o    (f_kind),
    .smp_re_o  (f_smp_re),
    .smp_im_o  (f_smp_im),
    .smp_ovf_o (f_smp_ovf),
    .eq_o      (f_eq),
    .neg_re_o  (f_neg_re),
    .neg_im_o  (f_neg_im),
    .mag_re_o  (f_mag_re),
    .mag_im_o  (f_mag_im),
    .den_o     (f_den)
  );

  // The multiply result is rounded and saturated here, ahead of the divider,
  // and then rides the divider's sideband with the other finished results.
  logic          f_neg [2];
  logic [MW-1:0] f_mag [2];
  logic [MW:0]   sh    [2];
  logic [MW:0]   lim   [2];
  logic [1:0]    msat;
  logic [DW-1:0] mm    [2];
  logic [DW-1:0] mres  [2];
  logic          is_mul;
  logic [DW-1:0] pre_re, pre_im;
  cau_flags_t    d_flags;

  assign f_neg  = '{f_neg_re, f_neg_im};
  assign f_mag  = '{f_mag_re, f_mag_im};
  assign is_mul = f_kind == OP_MUL;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sh[c]   = ((MW+1)'(f_mag[c]) + HALF) >> FRAC_BITS;
      lim[c]  = f_neg[c] ? LIM_NEG : LIM_POS;
      msat[c] = sh[c] > lim[c];
      mm[c]   = msat[c] ? lim[c][DW-1:0] : sh[c][DW-1:0];
      mres[c] = f_neg[c] ? DW'(0) - mm[c] : mm[c];
    end
  end

  always_comb begin
    pre_re           = is_mul ? mres[0] : f_smp_re;
    pre_im           = is_mul ? mres[1] : f_smp_im;
    d_flags.is_div   = f_kind == OP_DIV;
    d_flags.div_zero = (f_kind == OP_DIV) && (f_den == '0);
    d_flags.is_equal = f_eq;
    d_flags.ovf      = is_mul ? |msat : f_smp_ovf;
  end

  logic          d_valid;
  cau_flags_t    o_flags;
  cau_qstat_t    o_qst;
  logic [DW-1:0] o_pre_re, o_pre_im, o_q_re, o_q_im;
  logic [MW-1:0] o_r_re, o_r_im;
  logic [PW-1:0] o_den;

  cau_div #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (f_valid),
    .flags_i  (d_flags),
    .pre_re_i (pre_re),
    .pre_im_i (pre_im),
    .neg_re_i (f_neg_re),
    .neg_im_i (f_neg_im),
    .mag_re_i (f_mag_re),
    .mag_im_i (f_mag_im),
    .den_i    (f_den),
    .valid_o  (d_valid),
    .flags_o  (o_flags),
    .pre_re_o (o_pre_re),
    .pre_im_o (o_pre_im),
    .qst_o    (o_qst),
    .q_re_o   (o_q_re),
    .q_im_o   (o_q_im),
    .r_re_o   (o_r_re),
    .r_im_o   (o_r_im),
    .den_o    (o_den)
  );

  logic [DW-1:0] res_re, res_im;
  logic          is_equal, div_zero, overflow;

  cau_out #(
    .DATA_WIDTH(DW)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (d_valid),
    .flags_i    (o_flags),
    .pre_re_i   (o_pre_re),
    .pre_im_i   (o_pre_im),
    .qst_i      (o_qst),
    .q_re_i     (o_q_re),
    .q_im_i     (o_q_im),
    .r_re_i     (o_r_re),
    .r_im_i     (o_r_im),
    .den_i      (o_den),
    .valid_o    (out_valid),
    .res_re_o   (res_re),
    .res_im_o   (res_im),
    .is_equal_o (is_equal),
    .div_zero_o (div_zero),
    .overflow_o (overflow)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = ODW'({res_im, res_re});
  assign m_axis_tuser_o  = {overflow, div_zero, is_equal};

endmodule

// File: rtl/cau_checker.sv
// Port-level assertions for the complex arithmetic unit, bound to the top level.
module cau_checker #(
  parameter int unsigned DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o,
  input logic [2:0]                          m_axis_tuser_o
);

  // A held output word keeps its content.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // The input side only stalls behind a full, blocked output register.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output register");

  // Equality and divide by zero come from different operations.
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("is_equal and div_zero both set");

  // A zero divisor gives a zero result without overflow.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> (m_axis_tdata_o == '0) && !m_axis_tuser_o[2])
    else $error("divide by zero result not cleared");

  // The equality operation returns a zero result without overflow.
  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> (m_axis_tdata_o == '0) && !m_axis_tuser_o[2])
    else $error("equality result not cleared");

endmodule

bind complex_arithmetic_unit_top cau_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: test/tb_top.sv
// Testbench for the complex arithmetic unit: streamed operations checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import cau_pkg::*;

  localparam int DW = CAU_DATA_WIDTH;
  localparam int FB = CAU_FRAC_BITS;
  localparam int LATENCY = DW + 7;
  localparam int N_RANDOM = 1250;

  // One operation as it goes in, and the result expected back.
  typedef struct packed {
    logic [2:0]    kind;
    logic [DW-1:0] a_re, a_im, b_re, b_im;
  } op_word_t;

  typedef struct packed {
    logic [DW-1:0] res_re, res_im;
    logic          is_equal, div_zero, overflow;
  } alu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // a_re, a_im, b_re, b_im from bit 0 up.
  logic [4*DW-1:0] s_axis_tdata_i = '0;
  // kind.
  logic [2:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // res_re, res_im from bit 0 up.
  logic [2*DW-1:0] m_axis_tdata_o;
  // is_equal, div_zero, overflow from bit 0 up.
  logic [2:0] m_axis_tuser_o;

  complex_arithmetic_unit_top uut (.*);

  always #5 clk_i = ~clk_i;

  op_word_t    pending_ops[$];
  alu_result_t expected_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          kind_count[8];
  bit          stim_done = 1'b0;
  bit          hold_sender = 1'b0;

  // Saturates a signed wide value to DW bits, flagging overflow.
  function automatic logic [DW-1:0] clamp(input logic signed [199:0] v, inout logic ovf);
    logic signed [199:0] hi_lim, lo_lim;
    hi_lim = (200'sd1 <<< (DW - 1)) - 1;
    lo_lim = -(200'sd1 <<< (DW - 1));
    if (v > hi_lim) begin
      ovf = 1'b1;
      return hi_lim[DW-1:0];
    end
    if (v < lo_lim) begin
      ovf = 1'b1;
      return lo_lim[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Shift right by FB rounding to nearest, ties away from zero.
  function automatic logic signed [199:0] round_shift(input logic signed [199:0] v);
    logic signed [199:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (200'sd1 <<< (FB - 1))) >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  // Scaled quotient rounded to nearest, ties away from zero.
  function automatic logic signed [199:0] round_div(input logic signed [199:0] num,
                                                     input logic signed [199:0] den);
    logic signed [199:0] m, q, r;
    m = ((num < 0) ? -num : num) <<< FB;
    q = m / den;
    r = m % den;
    if (2 * r >= den) q = q + 1;
    return (num < 0) ? -q : q;
  endfunction

  function automatic alu_result_t compute_alu(input op_word_t w);
    alu_result_t r;
    logic signed [199:0] ar, ai, br, bi, den;
    logic ovf;
    ar = $signed(w.a_re); ai = $signed(w.a_im);
    br = $signed(w.b_re); bi = $signed(w.b_im);
    r = '{default: '0};
    ovf = 1'b0;
    case (w.kind)
      OP_ADD: begin
        r.res_re = clamp(ar + br, ovf);
        r.res_im = clamp(ai + bi, ovf);
      end
      OP_SUB: begin
        r.res_re = clamp(ar - br, ovf);
        r.res_im = clamp(ai - bi, ovf);
      end
      OP_MUL: begin
        r.res_re = clamp(round_shift(ar * br - ai * bi), ovf);
        r.res_im = clamp(round_shift(ar * bi + ai * br), ovf);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.div_zero = 1'b1;
        else begin
          r.res_re = clamp(round_div(ar * br + ai * bi, den), ovf);
          r.res_im = clamp(round_div(br * ai - ar * bi, den), ovf);
        end
      end
      OP_CONJ: begin
        r.res_re = clamp(ar, ovf);
        r.res_im = clamp(-ai, ovf);
      end
      OP_EQ: r.is_equal = (w.a_re == w.b_re) && (w.a_im == w.b_im);
      default: ;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return DW'($signed($urandom_range(0, 8)) - 4) <<< FB;
      4: return DW'($signed($urandom_range(0, 2000)) - 1000);
      default: return DW'($urandom());
    endcase
  endfunction

  task automatic queue_op(input logic [2:0] k, input logic [DW-1:0] a0, a1, b0, b1);
    op_word_t w;
    w.kind = k; w.a_re = a0; w.a_im = a1; w.b_re = b0; w.b_im = b1;
    pending_ops.push_back(w);
  endtask

  // Driver: bursts of random length with random gaps in between.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    op_word_t w;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) begin
          expected_results.push_back(compute_alu(
              '{s_axis_tuser_i, s_axis_tdata_i[DW-1:0], s_axis_tdata_i[2*DW-1:DW],
                s_axis_tdata_i[3*DW-1:2*DW], s_axis_tdata_i[4*DW-1:3*DW]}));
          kind_count[s_axis_tuser_i]++;
        end
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_ops.size() > 0 && !hold_sender) begin
          w = pending_ops.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= w.kind;
          s_axis_tdata_i <= {w.b_im, w.b_re, w.a_im, w.a_re};
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls follow a slowly changing pattern of its own.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    alu_result_t got, exp_r;
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
        default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      endcase
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        got.res_re = m_axis_tdata_o[DW-1:0];
        got.res_im = m_axis_tdata_o[2*DW-1:DW];
        got.is_equal = m_axis_tuser_o[0];
        got.div_zero = m_axis_tuser_o[1];
        got.overflow = m_axis_tuser_o[2];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word re=%h im=%h",
                                         got.res_re, got.res_im);
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp re=%h im=%h eq=%b dz=%b ov=%b, got %h %h %b %b %b",
                       exp_r.res_re, exp_r.res_im, exp_r.is_equal, exp_r.div_zero,
                       exp_r.overflow, got.res_re, got.res_im, got.is_equal,
                       got.div_zero, got.overflow);
          end
        end
      end
    end
  end

  initial begin
    logic [DW-1:0] mx, mn, one;
    op_word_t w;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    one = DW'(1) << FB;
    // Directed corners: saturation, conjugate of the most negative value, zero divide.
    queue_op(OP_ADD, mx, mn, mx, mn);
    queue_op(OP_ADD, mx, 0, mn, 0);
    queue_op(OP_SUB, mn, mx, mx, mn);
    queue_op(OP_MUL, one, one, one, one);
    queue_op(OP_MUL, mn, mn, mn, mn);
    queue_op(OP_MUL, mx, mx, mx, mn);
    queue_op(OP_MUL, DW'(1), 0, DW'(1) << (FB - 1), 0);
    queue_op(OP_MUL, -DW'(1), 0, DW'(1) << (FB - 1), 0);
    queue_op(OP_DIV, one, one, 0, 0);
    queue_op(OP_DIV, mx, mn, 0, 0);
    queue_op(OP_DIV, one, 0, one * 3, 0);
    queue_op(OP_DIV, mx, mx, DW'(1), 0);
    queue_op(OP_DIV, mn, mn, mn, mn);
    queue_op(OP_DIV, DW'(1), 0, DW'(2), 0);
    queue_op(OP_CONJ, mn, mn, 0, 0);
    queue_op(OP_CONJ, mx, mx, mx, mx);
    queue_op(OP_EQ, mn, mx, mn, mx);
    queue_op(OP_EQ, mn, mx, mn, mn);
    queue_op(3'd6, mx, mx, mx, mx);
    queue_op(3'd7, mn, mn, mn, mn);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Let the directed part drain fully before random traffic starts.
    wait (pending_ops.size() == 0);
    hold_sender = 1'b1;
    @(posedge clk_i);
    wait (expected_results.size() == 0 && !s_axis_tvalid_i);
    hold_sender = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      w.kind = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
      w.a_re = rand_operand(); w.a_im = rand_operand();
      if (w.kind == OP_EQ && $urandom_range(0, 1)) begin
        w.b_re = w.a_re; w.b_im = w.a_im;
      end else begin
        w.b_re = rand_operand(); w.b_im = rand_operand();
      end
      pending_ops.push_back(w);
    end
    wait (pending_ops.size() == 0);
    @(posedge clk_i);
    // The last word has been taken once the sender drops valid.
    wait (!s_axis_tvalid_i);
    wait (expected_results.size() == 0);
    repeat (LATENCY * 2) @(posedge clk_i);
    $display("Checked %0d result words: add %0d sub %0d mul %0d div %0d conj %0d eq %0d",
             results_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5]);
    $display("Unused codes %0d, mismatches %0d", kind_count[6] + kind_count[7], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
